// ===== sv/b2da_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// b2da_pkg
// Shared types and constants for the binary to decimal ASCII converter:
// the sequencer state type and the fixed widths and codes of the digit path.
// ----------------------------------------------------------------------------
package b2da_pkg;

    // Width of one packed BCD digit.
    localparam int unsigned DIGIT_BITS = 4;

    // Width of the ASCII digit field and of the byte that carries it.
    localparam int unsigned ASCII_BITS = 6;
    localparam int unsigned ODATA_BITS = 8;

    // ASCII code of the character '0'.
    localparam logic [ASCII_BITS-1:0] ASCII_ZERO = 6'd48;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_SKIP,
        S_EMIT
    } t_state;

endpackage : b2da_pkg
`default_nettype wire

// ===== sv/binary_to_decimal_ascii_core.sv =====
`default_nettype none
// Sequence: double dabble conversion (S_CONV), then leading zero digits are
//   dropped (S_SKIP), then each digit enters the output register (S_EMIT)
//   when that register is free, so output stalls hold the sequencer.
// Input: a new value is taken only in S_IDLE, after the last digit of the previous
//   one has been registered; the single shared shift-add-3 datapath is the limiting unit.
// Reset: synchronous, active low; idles the sequencer and clears the output valid.
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_core
// Converts one unsigned binary value per input transfer into its decimal
// text, most significant digit first, without leading zeros, one ASCII digit
// per output transfer, with tlast on the final digit.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_core #(
    parameter int unsigned VALUE_BITS = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input stream.
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [63:0] i_s_axis_tdata,   // [63:0] value
    // Output stream.
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [b2da_pkg::ODATA_BITS-1:0] o_m_axis_tdata, // [5:0] ascii_digit, [7:6] zero
    output logic             o_m_axis_tlast    // last digit of the run
);

    import b2da_pkg::*;

    // Decimal digits of 2^VALUE_BITS - 1: floor(VALUE_BITS * log10(2)) + 1.
    localparam int unsigned NDIG   = (VALUE_BITS * 1233) / 4096 + 1;
    localparam int unsigned BCD_W  = NDIG * DIGIT_BITS;
    localparam int unsigned CNT_W  = $clog2(VALUE_BITS + 1);
    localparam int unsigned DIG_W  = $clog2(NDIG + 1);

    t_state                  r_state, n_state;
    logic [VALUE_BITS-1:0]   r_bin, n_bin;
    logic [BCD_W-1:0]        r_bcd, n_bcd;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic [DIG_W-1:0]        r_dig, n_dig;
    logic                    r_out_valid, n_out_valid;
    logic [ASCII_BITS-1:0]   r_out_data, n_out_data;
    logic                    r_out_last, n_out_last;

    logic [BCD_W-1:0]        w_bcd_adj;
    logic [DIGIT_BITS-1:0]   w_top;
    logic                    w_out_free;

    // Add three to every BCD digit of five or more before the shift.
    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            if (r_bcd[i*DIGIT_BITS +: DIGIT_BITS] >= 4'd5) begin
                w_bcd_adj[i*DIGIT_BITS +: DIGIT_BITS] =
                    r_bcd[i*DIGIT_BITS +: DIGIT_BITS] + 4'd3;
            end else begin
                w_bcd_adj[i*DIGIT_BITS +: DIGIT_BITS] = r_bcd[i*DIGIT_BITS +: DIGIT_BITS];
            end
        end
    end

    assign w_top      = r_bcd[BCD_W-1 -: DIGIT_BITS];
    assign w_out_free = !r_out_valid || i_m_axis_tready;

    // Next state and datapath control.
    always_comb begin
        n_state     = r_state;
        n_bin       = r_bin;
        n_bcd       = r_bcd;
        n_cnt       = r_cnt;
        n_dig       = r_dig;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;

        // The output register empties on a transfer.
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_bin   = i_s_axis_tdata[VALUE_BITS-1:0];
                    n_bcd   = '0;
                    n_cnt   = CNT_W'(VALUE_BITS);
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                // One binary bit enters the BCD register per cycle.
                n_bcd = {w_bcd_adj[BCD_W-2:0], r_bin[VALUE_BITS-1]};
                n_bin = {r_bin[VALUE_BITS-2:0], 1'b0};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    n_dig   = DIG_W'(NDIG);
                    n_state = S_SKIP;
                end
            end
            S_SKIP: begin
                // Drop leading zero digits, but always keep the last one.
                if (w_top == '0 && r_dig != DIG_W'(1)) begin
                    n_bcd = {r_bcd[BCD_W-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}};
                    n_dig = r_dig - 1'b1;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                // Move the top digit into the output register when it is free.
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = ASCII_ZERO + {{(ASCII_BITS-DIGIT_BITS){1'b0}}, w_top};
                    n_out_last  = (r_dig == DIG_W'(1));
                    n_bcd       = {r_bcd[BCD_W-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}};
                    n_dig       = r_dig - 1'b1;
                    if (r_dig == DIG_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_dig       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
            r_dig       <= n_dig;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_bin      <= n_bin;
        r_bcd      <= n_bcd;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(ODATA_BITS-ASCII_BITS){1'b0}}, r_out_data};
    assign o_m_axis_tlast  = r_out_last;

`ifndef SYNTHESIS
    // An accepted value always starts a conversion.
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> (r_state == S_CONV))
        else $error("conversion did not start after an input transfer");

    // Digit emission never runs with an empty digit count.
    a_emit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT || r_state == S_SKIP) |-> (r_dig != '0))
        else $error("digit count empty while emitting");

    // A pending digit without tlast means more digits are still to come.
    a_more_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tlast) |-> (r_state == S_EMIT))
        else $error("run ended without a final digit");

    // The digit under the output pointer is a valid decimal digit.
    a_bcd_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (w_top <= 4'd9))
        else $error("invalid BCD digit reached the output");
`endif

endmodule : binary_to_decimal_ascii_core
`default_nettype wire

// ===== sim/tb_binary_to_decimal_ascii_core.sv =====
// ----------------------------------------------------------------------------
// tb_binary_to_decimal_ascii_core
// Self-checking testbench for the binary to decimal ASCII converter. Values
// are sent over the input stream in bursts with random gaps, and the output
// stream is stalled on a changing pattern. A local predictor turns every
// accepted value into its expected digit transfers, and each output transfer
// is compared field by field with the oldest expected digit.
// ----------------------------------------------------------------------------
module tb_binary_to_decimal_ascii_core;

    import b2da_pkg::*;

    localparam int unsigned VALUE_BITS = 64;
    localparam int unsigned MAX_DIGITS = 20;
    localparam int unsigned DRAIN_CYCLES = 100;
    localparam int unsigned RANDOM_ITEMS = 300;
    localparam logic [63:0] VALUE_MASK =
        (VALUE_BITS >= 64) ? {64{1'b1}} : ((64'd1 << VALUE_BITS) - 64'd1);

    // Output stall patterns.
    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_PERIODIC,
        RDY_SPARSE
    } t_ready_mode;

    // One expected digit transfer.
    typedef struct packed {
        logic [ASCII_BITS-1:0] ascii_digit;
        logic                  last;
    } t_digit;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [63:0] i_s_axis_tdata = '0;   // [63:0] value
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [ODATA_BITS-1:0] o_m_axis_tdata; // [5:0] ascii_digit, [7:6] zero
    logic        o_m_axis_tlast;

    t_digit      expected_digits[$];
    int unsigned error_count = 0;
    int unsigned values_sent = 0;
    int unsigned digits_checked = 0;
    int unsigned full_runs = 0;
    int unsigned zero_runs = 0;
    int unsigned burst_left = 0;

    t_ready_mode ready_mode = RDY_ALWAYS;
    int unsigned ready_span = 0;
    int unsigned ready_tick = 0;

    binary_to_decimal_ascii_core #(
        .VALUE_BITS(VALUE_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tlast (o_m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // Run limit, far above the slowest correct run.
    initial begin
        #(64'd10 * 64'd1_500_000);
        $display("Test completed with failures");
        $finish;
    end

    // Queue the decimal digits of one value, most significant first.
    function automatic void predict_decimal_text(input logic [63:0] value);
        logic [63:0]           rest;
        logic [ASCII_BITS-1:0] reversed[MAX_DIGITS];
        int                    count;
        t_digit                digit;
        rest = value & VALUE_MASK;
        count = 0;
        do begin
            reversed[count] = ASCII_ZERO + ASCII_BITS'(rest % 64'd10);
            rest = rest / 64'd10;
            count++;
        end while (rest != 0 && count < MAX_DIGITS);
        for (int k = 0; k < count; k++) begin
            digit.ascii_digit = reversed[count - 1 - k];
            digit.last = (k == count - 1);
            expected_digits.push_back(digit);
        end
        if (count == MAX_DIGITS) full_runs++;
        if ((value & VALUE_MASK) == 0) zero_runs++;
    endfunction

    // Send one value; the sender works in bursts with random gaps in between.
    task automatic send_value(input logic [63:0] value);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            if (gap != 0) begin
                i_s_axis_tvalid <= 1'b0;
                i_s_axis_tdata <= {$urandom, $urandom};
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= value;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_decimal_text(value);
        values_sent++;
    endtask

    // Drop valid and wait until every expected digit has come out.
    task automatic wait_for_drain();
        i_s_axis_tvalid <= 1'b0;
        while (expected_digits.size() != 0) @(posedge i_clk);
    endtask

    // Power of ten for exponents 0 to 19.
    function automatic logic [63:0] power_of_ten(input int unsigned exponent);
        logic [63:0] p;
        p = 64'd1;
        for (int k = 0; k < exponent; k++) p = p * 64'd10;
        return p;
    endfunction

    // Zero, one, the largest value and bit patterns that toggle every bit.
    task automatic test_extremes();
        send_value(64'd0);
        send_value(64'd1);
        send_value(64'hFFFF_FFFF_FFFF_FFFF);
        send_value(64'h8000_0000_0000_0000);
        send_value(64'hAAAA_AAAA_AAAA_AAAA);
        send_value(64'h5555_5555_5555_5555);
        send_value(64'h8000_0000_0000_0001);
        send_value(64'h0000_0000_FFFF_FFFF);
        send_value(64'h0000_0001_0000_0000);
    endtask

    // Values on either side of a change in the number of digits.
    task automatic test_digit_boundaries();
        send_value(64'd9);
        send_value(64'd10);
        send_value(64'd99);
        send_value(64'd100);
        send_value(64'd12345);
        send_value(power_of_ten(18) - 64'd1);
        send_value(power_of_ten(18));
        send_value(power_of_ten(19) - 64'd1);
        send_value(power_of_ten(19));
        send_value(power_of_ten(19) + 64'd1);
    endtask

    // Random values of random length, with some near powers of ten.
    task automatic test_random_values(input int unsigned item_count);
        logic [63:0] value;
        int unsigned nbits;
        for (int n = 0; n < item_count; n++) begin
            if ($urandom_range(0, 7) == 0) begin
                value = power_of_ten($urandom_range(0, 19));
                value = value + 64'($urandom_range(0, 2)) - 64'd1;
            end else begin
                nbits = $urandom_range(1, 64);
                value = {$urandom, $urandom} >> (64 - nbits);
            end
            send_value(value);
        end
    endtask

    // The sender holds off until the output is empty, then resumes at once.
    task automatic test_drain_and_resume();
        wait_for_drain();
        burst_left = 8;
        send_value(64'hFFFF_FFFF_FFFF_FFFF);
        send_value(64'd0);
        send_value(64'd7);
        send_value({$urandom, $urandom});
    endtask

    // Output stall pattern, changing to a random mode after a random span.
    always @(posedge i_clk) begin
        if (ready_span == 0) begin
            ready_mode <= t_ready_mode'($urandom_range(0, 3));
            ready_span <= $urandom_range(20, 200);
        end else begin
            ready_span <= ready_span - 1;
        end
        ready_tick <= ready_tick + 1;
        case (ready_mode)
            RDY_ALWAYS:   i_m_axis_tready <= 1'b1;
            RDY_COIN:     i_m_axis_tready <= 1'($urandom_range(0, 1));
            RDY_PERIODIC: i_m_axis_tready <= (ready_tick % 3) != 0;
            default:      i_m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Compare each output transfer with the oldest expected digit.
    always @(posedge i_clk) begin
        t_digit want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_digits.size() == 0) begin
                $error("Unexpected digit transfer: ascii_digit %0d last %0b",
                       o_m_axis_tdata[ASCII_BITS-1:0], o_m_axis_tlast);
                error_count++;
            end else begin
                want = expected_digits.pop_front();
                digits_checked++;
                if (o_m_axis_tdata[ASCII_BITS-1:0] !== want.ascii_digit) begin
                    $error("ascii_digit: expected %0d, actual %0d",
                           want.ascii_digit, o_m_axis_tdata[ASCII_BITS-1:0]);
                    error_count++;
                end
                if (o_m_axis_tlast !== want.last) begin
                    $error("last: expected %0b, actual %0b", want.last, o_m_axis_tlast);
                    error_count++;
                end
                if (o_m_axis_tdata[ODATA_BITS-1:ASCII_BITS] !== '0) begin
                    $error("tdata padding: expected 0, actual %0d",
                           o_m_axis_tdata[ODATA_BITS-1:ASCII_BITS]);
                    error_count++;
                end
            end
        end
    end

    // Test sequence.
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes();
        test_digit_boundaries();
        test_random_values(RANDOM_ITEMS / 2);
        test_drain_and_resume();
        test_random_values(RANDOM_ITEMS - RANDOM_ITEMS / 2);

        // Let the last runs come out, then allow time for any stray transfer.
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Converted %0d values: %0d of full 20-digit length, %0d of zero.",
                 values_sent, full_runs, zero_runs);
        $display("Checked %0d digit transfers under random input gaps and output stalls.",
                 digits_checked);
        if (error_count == 0 && expected_digits.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
